// ===== rtl/ir_nec_pkg.sv =====
// Shared constants, types and helpers for the NEC infrared pulse decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ir_nec_pkg;

   // Frame geometry
   localparam int unsigned FRAME_BITS = 32;
   localparam int unsigned COUNT_W    = $clog2(FRAME_BITS + 1);

   // Field widths
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned CODE_W     = 8;
   localparam int unsigned BITCOUNT_W = 6;
   localparam int unsigned KEY_LSB    = 16;

   // Register file
   localparam int unsigned NUM_REGS   = 6;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MIN_VALID = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHORT     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LONG      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_REPEAT    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_HEADER    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LEAD      = 3'd5;

   localparam logic [TIME_W-1:0] RST_MIN_VALID = 16'd250;
   localparam logic [TIME_W-1:0] RST_SHORT     = 16'd1200;
   localparam logic [TIME_W-1:0] RST_LONG      = 16'd2000;
   localparam logic [TIME_W-1:0] RST_REPEAT    = 16'd3000;
   localparam logic [TIME_W-1:0] RST_HEADER    = 16'd6000;
   localparam logic [TIME_W-1:0] RST_LEAD      = 16'd12000;

   // Request kinds
   localparam logic REQ_PULSE    = 1'b0;
   localparam logic REQ_KEY_READ = 1'b1;

   // Pulse classes
   typedef logic [2:0] pulse_class_type;
   localparam pulse_class_type CLS_ERROR  = 3'd0;
   localparam pulse_class_type CLS_SHORT  = 3'd1;
   localparam pulse_class_type CLS_LONG   = 3'd2;
   localparam pulse_class_type CLS_REPEAT = 3'd3;
   localparam pulse_class_type CLS_HEADER = 3'd4;
   localparam pulse_class_type CLS_LEAD   = 3'd5;

   typedef struct packed {
      logic [TIME_W-1:0] min_valid_time;
      logic [TIME_W-1:0] short_limit;
      logic [TIME_W-1:0] long_limit;
      logic [TIME_W-1:0] repeat_limit;
      logic [TIME_W-1:0] header_limit;
      logic [TIME_W-1:0] lead_limit;
   } thresholds_type;

   // Control handed from the input stage to the frame stage
   typedef struct packed {
      logic            advance;
      logic            key_read;
      pulse_class_type cls;
   } step_type;

   // Command byte; bits above the frame read as zero
   function automatic logic [CODE_W-1:0] key_code_of(input logic [FRAME_BITS-1:0] frame);
      logic [63:0] wide;
      wide = 64'(frame);
      return wide[KEY_LSB +: CODE_W];
   endfunction

endpackage

// ===== rtl/ir_nec_if.sv =====
// Valid/ready channel interfaces for request and response transfers.
// Depends on ir_nec_pkg for field widths.
`timescale 1ns / 1ps

interface ir_nec_req_if;
   import ir_nec_pkg::*;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] pulse_time;

   modport source (output valid, output req_type, output pulse_time, input ready);
   modport sink   (input valid, input req_type, input pulse_time, output ready);
endinterface

interface ir_nec_rsp_if;
   import ir_nec_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  key_valid;
   logic [CODE_W-1:0]     key_code;
   logic [BITCOUNT_W-1:0] bit_count;

   modport source (output valid, output key_valid, output key_code, output bit_count,
                   input ready);
   modport sink   (input valid, input key_valid, input key_code, input bit_count,
                   output ready);
endinterface

// ===== rtl/ir_nec_pulse_decoder.sv =====
// Top level of the NEC infrared pulse decoder: input stage, wiring.
// Depends on ir_nec_pkg, ir_nec_if, ir_nec_csr, ir_nec_classify, ir_nec_frame.
`timescale 1ns / 1ps

// Pulse-distance IR remote decoder. Each request transfer carries either an
// edge-to-edge time (req_type 0) or a key read (req_type 1); each gives exactly
// one response transfer. Times are classed against six APB thresholds
// (byte addresses 0x00..0x14: min_valid_time, short_limit, long_limit,
// repeat_limit, header_limit, lead_limit), first match wins. Short/long shift
// 0/1 into the frame MSB, header clears, repeat completes an empty frame,
// error/lead zero the count; a complete frame ignores all pulses until a key
// read returns bits 23..16 and clears the count. Structure: two register stages
// (input register, then class + frame update into the response register), so
// a response passes both registers and one transfer per cycle is sustained
// while the receiver keeps ready high; the frame update is made on that stage.
// Thresholds should only be written while no transfer is in flight.

module ir_nec_pulse_decoder (
   input  logic                                clock,
   input  logic                                reset,
   ir_nec_req_if.sink                          req_in,
   ir_nec_rsp_if.source                        rsp_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ir_nec_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ir_nec_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ir_nec_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import ir_nec_pkg::*;

   thresholds_type    thresholds;
   pulse_class_type   cls;
   step_type          step;
   logic              out_free;
   logic              req_take;

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_type_ff;
   logic [TIME_W-1:0] s1_time_ff;

   ir_nec_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .thresholds (thresholds)
   );

   // Stage moves on when the response register is empty or being drained
   assign step.advance  = s1_valid_ff & out_free;
   assign step.key_read = (s1_type_ff == REQ_KEY_READ);
   assign step.cls      = cls;

   // Ready does not wait for the response side to drain: a held item is
   // replaced in the same cycle it moves on.
   assign req_in.ready = ~s1_valid_ff | out_free;
   assign req_take     = req_in.valid & req_in.ready;

   always_comb begin
      if (req_take)          s1_valid_in = 1'b1;
      else if (step.advance) s1_valid_in = 1'b0;
      else                   s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff <= req_in.req_type;
         s1_time_ff <= req_in.pulse_time;
      end
   end

   ir_nec_classify u_classify (
      .pulse_time (s1_time_ff),
      .thresholds (thresholds),
      .cls        (cls)
   );

   ir_nec_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .out_free (out_free),
      .rsp_out  (rsp_out)
   );

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("held request dropped while response stalled");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_out.valid) |-> $past(s1_valid_ff))
      else $error("response without a held request");

   a_take_free: assert property (@(posedge clock) disable iff (reset)
      req_take && s1_valid_ff |-> step.advance)
      else $error("request taken over a held item");

endmodule

// ===== rtl/ir_nec_csr.sv =====
// APB-style threshold register file for the pulse decoder.
// Depends on ir_nec_pkg.
`timescale 1ns / 1ps

module ir_nec_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ir_nec_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ir_nec_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ir_nec_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready,
   output ir_nec_pkg::thresholds_type          thresholds
);
   import ir_nec_pkg::*;

   thresholds_type          thr_ff, thr_in;
   logic [REG_IDX_W-1:0]    idx;
   logic                    wr_en;
   logic [TIME_W-1:0]       wval;
   logic [TIME_W-1:0]       rval;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite & pready;
   assign wval   = pwdata[TIME_W-1:0];

   always_comb begin
      thr_in = thr_ff;
      if (wr_en) begin
         unique case (idx)
            REG_MIN_VALID: thr_in.min_valid_time = wval;
            REG_SHORT:     thr_in.short_limit    = wval;
            REG_LONG:      thr_in.long_limit     = wval;
            REG_REPEAT:    thr_in.repeat_limit   = wval;
            REG_HEADER:    thr_in.header_limit   = wval;
            REG_LEAD:      thr_in.lead_limit     = wval;
            default:       thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MIN_VALID: rval = thr_ff.min_valid_time;
         REG_SHORT:     rval = thr_ff.short_limit;
         REG_LONG:      rval = thr_ff.long_limit;
         REG_REPEAT:    rval = thr_ff.repeat_limit;
         REG_HEADER:    rval = thr_ff.header_limit;
         REG_LEAD:      rval = thr_ff.lead_limit;
         default:       rval = '0;
      endcase
   end

   assign prdata     = CSR_DATA_W'(rval);
   assign thresholds = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.min_valid_time <= RST_MIN_VALID;
         thr_ff.short_limit    <= RST_SHORT;
         thr_ff.long_limit     <= RST_LONG;
         thr_ff.repeat_limit   <= RST_REPEAT;
         thr_ff.header_limit   <= RST_HEADER;
         thr_ff.lead_limit     <= RST_LEAD;
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

// ===== rtl/ir_nec_classify.sv =====
// Threshold cascade that sorts a pulse time into one class.
// Depends on ir_nec_pkg.
`timescale 1ns / 1ps

module ir_nec_classify (
   input  logic [ir_nec_pkg::TIME_W-1:0] pulse_time,
   input  ir_nec_pkg::thresholds_type    thresholds,
   output ir_nec_pkg::pulse_class_type   cls
);
   import ir_nec_pkg::*;

   // First match wins, whatever the order of the limits
   always_comb begin
      priority if (pulse_time < thresholds.min_valid_time) cls = CLS_ERROR;
      else if (pulse_time < thresholds.short_limit)        cls = CLS_SHORT;
      else if (pulse_time < thresholds.long_limit)         cls = CLS_LONG;
      else if (pulse_time < thresholds.repeat_limit)       cls = CLS_REPEAT;
      else if (pulse_time < thresholds.header_limit)       cls = CLS_HEADER;
      else if (pulse_time < thresholds.lead_limit)         cls = CLS_LEAD;
      else                                                 cls = CLS_ERROR;
   end

endmodule

// ===== rtl/ir_nec_frame.sv =====
// Frame state (shift register, bit count) and the response register.
// Depends on ir_nec_pkg and ir_nec_rsp_if.
`timescale 1ns / 1ps

module ir_nec_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  ir_nec_pkg::step_type  step,
   output logic                  out_free,
   ir_nec_rsp_if.source          rsp_out
);
   import ir_nec_pkg::*;

   localparam logic [COUNT_W-1:0] FULL = COUNT_W'(FRAME_BITS);

   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0]    held_ff, held_in;
   logic                  full;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  key_valid_ff, key_valid_in;
   logic [CODE_W-1:0]     key_code_ff, key_code_in;
   logic [BITCOUNT_W-1:0] bit_count_ff;

   assign full     = (held_ff == FULL);
   assign out_free = ~rsp_valid_ff | rsp_out.ready;

   always_comb begin
      shift_in     = shift_ff;
      held_in      = held_ff;
      key_valid_in = 1'b0;
      key_code_in  = '0;
      if (step.key_read) begin
         if (full) begin
            key_valid_in = 1'b1;
            key_code_in  = key_code_of(shift_ff);
            held_in      = '0;
         end
      end else if (!full) begin
         // LSB first: new bits enter at the top
         unique case (step.cls)
            CLS_SHORT: begin
               shift_in = {1'b0, shift_ff[FRAME_BITS-1:1]};
               held_in  = held_ff + COUNT_W'(1);
            end
            CLS_LONG: begin
               shift_in = {1'b1, shift_ff[FRAME_BITS-1:1]};
               held_in  = held_ff + COUNT_W'(1);
            end
            CLS_HEADER: begin
               shift_in = '0;
               held_in  = '0;
            end
            CLS_REPEAT: begin
               if (held_ff == '0) held_in = FULL;
            end
            default: held_in = '0;   // error and lead
         endcase
      end
   end

   always_comb begin
      if (step.advance)      rsp_valid_in = 1'b1;
      else if (rsp_out.ready) rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step.advance) begin
            shift_ff <= shift_in;
            held_ff  <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step.advance) begin
         key_valid_ff <= key_valid_in;
         key_code_ff  <= key_code_in;
         bit_count_ff <= BITCOUNT_W'(held_in);
      end
   end

   assign rsp_out.valid     = rsp_valid_ff;
   assign rsp_out.key_valid = key_valid_ff;
   assign rsp_out.key_code  = key_code_ff;
   assign rsp_out.bit_count = bit_count_ff;

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FULL)
      else $error("bit count beyond frame length");

   a_key_clears: assert property (@(posedge clock) disable iff (reset)
      step.advance && step.key_read && full |=> held_ff == '0)
      else $error("key read of complete frame did not clear count");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !key_valid_ff |-> key_code_ff == '0)
      else $error("key code set without a valid key");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      step.advance && !step.key_read && full |=> held_ff == FULL && $stable(shift_ff))
      else $error("pulse altered a complete frame");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the NEC infrared pulse decoder: random and directed
// edge times and key reads, checked against a cycle-free decoder model below.
// Depends on ir_nec_pkg, ir_nec_if and the ir_nec_pulse_decoder RTL.
`timescale 1ns / 1ps

module testbench;
   import ir_nec_pkg::*;

   localparam int CLOCK_HALF     = 2;
   localparam int RESET_CYCLES   = 3;
   localparam int DRAIN_CYCLES   = 10;    // two register stages plus margin
   localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch
   localparam int WATCHDOG_LIMIT = 3000;  // well beyond LONG_HOLD and any random stall

   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] pulse_time;
   } pulse_item_type;

   typedef struct packed {
      logic                  key_valid;
      logic [CODE_W-1:0]     key_code;
      logic [BITCOUNT_W-1:0] bit_count;
   } key_result_type;

   typedef logic [NUM_REGS-1:0][TIME_W-1:0] limit_set_type;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ir_nec_req_if req_bus ();
   ir_nec_rsp_if rsp_bus ();

   ir_nec_pulse_decoder u_top (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #CLOCK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------
   // Decoder model: thresholds, shift register and bit count as the block holds
   // them. Updated once per accepted request transfer, in acceptance order.
   // ---------------------------------------------------------------------------
   limit_set_type         limits;
   logic [FRAME_BITS-1:0] frame_bits;
   int unsigned           held_bits;

   function automatic pulse_class_type class_of(input logic [TIME_W-1:0] t);
      if (t < limits[REG_MIN_VALID]) return CLS_ERROR;
      if (t < limits[REG_SHORT])     return CLS_SHORT;
      if (t < limits[REG_LONG])      return CLS_LONG;
      if (t < limits[REG_REPEAT])    return CLS_REPEAT;
      if (t < limits[REG_HEADER])    return CLS_HEADER;
      if (t < limits[REG_LEAD])      return CLS_LEAD;
      return CLS_ERROR;
   endfunction

   function automatic key_result_type decode_step(input pulse_item_type item);
      key_result_type  res;
      pulse_class_type cls;
      res = '0;
      if (item.req_type == REQ_KEY_READ) begin
         // key read: command byte only once the frame is complete
         if (held_bits == FRAME_BITS) begin
            res.key_valid = 1'b1;
            res.key_code  = frame_bits[KEY_LSB +: CODE_W];
            held_bits     = 0;
         end
      end else if (held_bits < FRAME_BITS) begin
         // a complete frame ignores every pulse until it is read
         cls = class_of(item.pulse_time);
         case (cls)
            CLS_SHORT: begin
               frame_bits = {1'b0, frame_bits[FRAME_BITS-1:1]};
               held_bits++;
            end
            CLS_LONG: begin
               frame_bits = {1'b1, frame_bits[FRAME_BITS-1:1]};
               held_bits++;
            end
            CLS_HEADER: begin
               frame_bits = '0;
               held_bits  = 0;
            end
            CLS_REPEAT: begin
               if (held_bits == 0) held_bits = FRAME_BITS;
            end
            default: begin
               held_bits = 0;
            end
         endcase
      end
      res.bit_count = BITCOUNT_W'(held_bits);
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------------
   pulse_item_type ir_events[$];      // requests waiting to be offered
   key_result_type expected_keys[$];  // predicted responses, oldest first
   int          items_queued = 0;
   int          items_taken = 0;
   int          responses_checked = 0;
   int          keys_returned = 0;
   int          settings_used = 1;  // reset thresholds count as one
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_req = 1'b0;
   int          hold_count = 0;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h (response %0d)",
               $time, what, got, want, responses_checked);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: predicts on each accepted transfer, then offers the next
   // queued item unless the sender idles this cycle.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      pulse_item_type taken;
      pulse_item_type queued_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.req_type   = req_bus.req_type;
            taken.pulse_time = req_bus.pulse_time;
            expected_keys.push_back(decode_step(taken));
            items_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (ir_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               queued_item = ir_events.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= queued_item.req_type;
               req_bus.pulse_time <= queued_item.pulse_time;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: checks each transfer field by field; ready stalls at
   // random, or is held low while hold_req is set until hold_count reaches LONG_HOLD.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses_checked++;
            if (rsp_bus.key_valid === 1'b1) keys_returned++;
            if (expected_keys.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_bus.bit_count, 0);
            end else begin
               want = expected_keys.pop_front();
               if (rsp_bus.key_valid !== want.key_valid)
                  report_mismatch("key_valid", rsp_bus.key_valid, want.key_valid);
               if (rsp_bus.key_code !== want.key_code)
                  report_mismatch("key_code", rsp_bus.key_code, want.key_code);
               if (rsp_bus.bit_count !== want.bit_count)
                  report_mismatch("bit_count", rsp_bus.bit_count, want.bit_count);
            end
         end
         if (hold_req && hold_count < LONG_HOLD) begin
            hold_count    <= hold_count + 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (!hold_req) hold_count <= 0;
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: any transfer on either channel or the register port restarts it.
   // ---------------------------------------------------------------------------
   int   idle_cycles = 0;
   logic transfer_now;
   assign transfer_now = (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                         || (psel && penable);

   always @(posedge clock) begin
      if (reset || transfer_now) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
                  idle_cycles, expected_keys.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Register port: setup cycle, then access cycle; prdata sampled at the edge
   // that completes the access.
   // ---------------------------------------------------------------------------
   task automatic csr_access(input logic wr, input int idx, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= CSR_ADDR_W'(idx * 4);
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Only called with the block idle; model thresholds follow the writes.
   task automatic load_limits(input limit_set_type set);
      logic [CSR_DATA_W-1:0] readback;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_access(1'b1, i, CSR_DATA_W'(set[i]), readback);
         limits[i] = set[i];
      end
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_access(1'b0, i, '0, readback);
         if (readback !== CSR_DATA_W'(limits[i]))
            report_mismatch("register readback", readback, limits[i]);
      end
      settings_used++;
   endtask

   function automatic limit_set_type limit_set(input int min_valid, input int short_lim,
                                               input int long_lim, input int repeat_lim,
                                               input int header_lim, input int lead_lim);
      limit_set_type set;
      set[REG_MIN_VALID] = TIME_W'(min_valid);
      set[REG_SHORT]     = TIME_W'(short_lim);
      set[REG_LONG]      = TIME_W'(long_lim);
      set[REG_REPEAT]    = TIME_W'(repeat_lim);
      set[REG_HEADER]    = TIME_W'(header_lim);
      set[REG_LEAD]      = TIME_W'(lead_lim);
      return set;
   endfunction

   // Random but ascending thresholds, so every class has a window.
   function automatic limit_set_type ordered_limits();
      limit_set_type set;
      int            level;
      level = $urandom_range(400);
      for (int i = 0; i < NUM_REGS; i++) begin
         set[i] = TIME_W'(level);
         level  = level + $urandom_range(4000, 1);
         if (level > 65535) level = 65535;
      end
      return set;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------
   task automatic wait_idle();
      while (items_taken != items_queued || expected_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_item(input logic kind, input logic [TIME_W-1:0] t);
      pulse_item_type item;
      item.req_type   = kind;
      item.pulse_time = t;
      ir_events.push_back(item);
      items_queued++;
   endtask

   // A time inside the window of the wanted class; any time if that window is empty.
   function automatic logic [TIME_W-1:0] time_for(input pulse_class_type cls);
      int lo;
      int hi;
      case (cls)
         CLS_SHORT:  begin lo = limits[REG_MIN_VALID]; hi = limits[REG_SHORT];  end
         CLS_LONG:   begin lo = limits[REG_SHORT];     hi = limits[REG_LONG];   end
         CLS_REPEAT: begin lo = limits[REG_LONG];      hi = limits[REG_REPEAT]; end
         CLS_HEADER: begin lo = limits[REG_REPEAT];    hi = limits[REG_HEADER]; end
         CLS_LEAD:   begin lo = limits[REG_HEADER];    hi = limits[REG_LEAD];   end
         default: begin
            if ($urandom_range(1) == 0) begin
               lo = 0;
               hi = limits[REG_MIN_VALID];
            end else begin
               lo = limits[REG_LEAD];
               hi = 65536;
            end
         end
      endcase
      if (hi > lo) return TIME_W'($urandom_range(hi - 1, lo));
      return TIME_W'($urandom_range(65535));
   endfunction

   task automatic push_pulse(input pulse_class_type cls);
      push_item(REQ_PULSE, time_for(cls));
   endtask

   task automatic push_key();
      push_item(REQ_KEY_READ, TIME_W'($urandom_range(65535)));
   endtask

   task automatic push_noise(input int n);
      repeat (n) begin
         if ($urandom_range(7) == 0)
            push_key();
         else if ($urandom_range(1) == 0)
            push_item(REQ_PULSE, TIME_W'($urandom_range(65535)));
         else
            push_pulse(pulse_class_type'($urandom_range(CLS_LEAD)));
      end
   endtask

   // Optional lead, header, data bits and a key read; one in five is cut short.
   task automatic push_frame();
      int stop;
      stop = ($urandom_range(4) == 0) ? $urandom_range(FRAME_BITS - 1) : FRAME_BITS;
      if ($urandom_range(1) == 0) push_pulse(CLS_LEAD);
      push_pulse(CLS_HEADER);
      for (int i = 0; i < stop; i++)
         push_pulse($urandom_range(1) ? CLS_LONG : CLS_SHORT);
      if (stop < FRAME_BITS && $urandom_range(1) == 0) push_noise(1);
      // pulses after a complete frame must be ignored
      if (stop == FRAME_BITS && $urandom_range(3) == 0) push_noise($urandom_range(3, 1));
      push_key();
      if ($urandom_range(3) == 0) push_key();
   endtask

   task automatic push_repeat_code();
      push_pulse(CLS_LEAD);
      push_pulse(CLS_REPEAT);
      push_key();
   endtask

   task automatic push_random(input int count);
      int start;
      start = items_queued;
      while (items_queued - start < count) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: push_frame();
            6:                push_repeat_code();
            default:          push_noise($urandom_range(8, 1));
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_PULSE;
      req_bus.pulse_time = '0;
      rsp_bus.ready      = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      limits     = limit_set(RST_MIN_VALID, RST_SHORT, RST_LONG, RST_REPEAT, RST_HEADER,
                             RST_LEAD);
      frame_bits = '0;
      held_bits  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset thresholds: class edges, repeat completion, ignored
      // pulses on a complete frame, reads of complete and incomplete frames.
      push_item(REQ_KEY_READ, 16'hFFFF);  // nothing complete
      push_item(REQ_PULSE, 0);            // error
      push_item(REQ_PULSE, 2000);         // repeat on empty frame: complete
      push_item(REQ_PULSE, 249);          // ignored while complete
      push_item(REQ_PULSE, 3000);
      push_item(REQ_PULSE, 65535);
      push_item(REQ_KEY_READ, 0);         // valid read, clears count
      push_item(REQ_KEY_READ, 16'h5A5A);  // no longer complete
      push_item(REQ_PULSE, 250);          // short
      push_item(REQ_PULSE, 1999);         // long
      push_item(REQ_PULSE, 2999);         // repeat with bits held: no effect
      push_item(REQ_PULSE, 1199);
      push_item(REQ_PULSE, 1200);
      push_item(REQ_PULSE, 6000);         // lead zeroes the count
      push_item(REQ_PULSE, 1999);
      push_item(REQ_PULSE, 5999);         // header clears
      push_item(REQ_PULSE, 1250);
      push_item(REQ_PULSE, 11999);
      push_item(REQ_PULSE, 12000);        // error above lead
      push_item(REQ_PULSE, 1500);
      push_item(REQ_PULSE, 65535);
      push_item(REQ_PULSE, 249);
      push_item(REQ_PULSE, 2000);
      push_item(REQ_KEY_READ, 16'hFFFF);
      push_random(250);
      wait_idle();

      // Widest windows, sender idling
      load_limits(limit_set(0, 1000, 2000, 3000, 4000, 65535));
      send_idle_pct = 73;
      push_random(300);
      wait_idle();

      // Random ordered thresholds, receiver stalling; first a long hold-off so
      // the block fills and refuses requests
      load_limits(ordered_limits());
      send_idle_pct  = 0;
      recv_stall_pct = 73;
      hold_req <= 1'b1;
      push_random(60);
      while (hold_count < LONG_HOLD) @(posedge clock);
      hold_req <= 1'b0;
      push_random(250);
      wait_idle();

      // Everything short bar the top time; both sides idling lightly
      load_limits(limit_set(0, 65535, 65535, 65535, 65535, 65535));
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      push_random(200);
      wait_idle();

      // Unordered thresholds: every time is an error
      load_limits(limit_set(65535, 0, 0, 0, 0, 0));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      push_random(80);
      wait_idle();

      // Random ordered again, with a pause until the block has drained
      load_limits(ordered_limits());
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      push_random(150);
      wait_idle();
      push_random(150);
      wait_idle();

      $display("Summary: %0d requests, %0d responses checked, %0d complete key reads,",
               items_taken, responses_checked, keys_returned);
      $display("         %0d threshold settings, %0d mismatches", settings_used, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ir_nec_pkg.sv
rtl/ir_nec_if.sv
rtl/ir_nec_csr.sv
rtl/ir_nec_classify.sv
rtl/ir_nec_frame.sv
rtl/ir_nec_pulse_decoder.sv
sim/testbench.sv
